### src/tvcp_pkg.sv
// ----------------------------------------------------------------------------
// tvcp_pkg
// Shared types and constants for the topic/value command parser.
// ----------------------------------------------------------------------------
package tvcp_pkg;

  localparam int TOPIC_LEN_DEF = 8;
  localparam int DIGIT_LEN     = 3;

  typedef enum logic {
    OP_RX_BYTE  = 1'b0,
    OP_CMP_EDGE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_POSITION = 2'd1,
    KIND_TOGGLE   = 2'd2,
    KIND_LIGHT    = 2'd3
  } kind_t;

  // kind_flags bit positions
  localparam int FLAG_POS = 0;
  localparam int FLAG_TOG = 1;
  localparam int FLAG_LIT = 2;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [63:0] KW_POS = "Position";
  localparam logic [63:0] KW_TOG = "Toggle";
  localparam logic [63:0] KW_LIT = "Light";
  localparam int KW_POS_LEN = 8;
  localparam int KW_TOG_LEN = 6;
  localparam int KW_LIT_LEN = 5;

  localparam logic [5:0] SERVO_RESET = 6'd48;
  localparam logic [5:0] SERVO_EDGE  = 6'd30;
  localparam logic [9:0] DAC_RESET   = 10'd656;

  // ceil(x/100) numerator is divided by 100 as (x * 1311) >> 17, exact for x < 4096
  localparam logic [21:0] RECIP_100 = 22'd1311;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] rx_byte;
  } tvcp_in_t;

  typedef struct packed {
    logic [5:0] servo_duty;
    logic [9:0] dac_duty;
    logic       command_done;
    kind_t      topic_kind;
  } tvcp_out_t;

  function automatic logic [7:0] kw_char(input logic [63:0] kw, input int len,
                                         input int unsigned pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < len) c = kw[8*(len-1-pos) +: 8];
    return c;
  endfunction

endpackage

### src/topic_value_command_parser.sv
// ----------------------------------------------------------------------------
// topic_value_command_parser
// Parses '!' topic ':' value CR/LF messages and drives servo and DAC duty.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall/item): one transaction per received
//   serial byte (opcode OP_RX_BYTE) or comparator falling edge
//   (opcode OP_CMP_EDGE).
//   result channel (result_valid/result_stall/result): exactly one transaction
//   per item, carrying servo and DAC duty, the latched topic kind and a flag
//   that marks the byte which ended a message.
//   Path: a transaction accepted into the input register is loaded into
//   the result register once that register is empty or its result is taken,
//   and can be taken from then on; parser state is updated by a single level
//   of logic between the two.
//   Throughput: one item per cycle, limited only by the result side.
//   Reset (rst, synchronous) clears the buffers, index and topic kind, and
//   sets servo duty to 48 and DAC duty to 656; both channels go empty.
//   When result_stall is high while a result is valid the result register holds; the input register
//   still fills, after which item_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module topic_value_command_parser
  import tvcp_pkg::*;
#(
  parameter int TOPIC_LEN = TOPIC_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  tvcp_in_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output tvcp_out_t result
);

  localparam int IDX_W = $clog2(TOPIC_LEN + 1);

  logic     s1_valid;
  tvcp_in_t s1_item;
  logic     advance;

  logic              in_value_part, in_value_part_next;
  logic [IDX_W-1:0]  char_index, char_index_next;
  logic [7:0]        topic_buf [TOPIC_LEN];
  logic [7:0]        topic_buf_next [TOPIC_LEN];
  logic [7:0]        digit_buf [DIGIT_LEN];
  logic [7:0]        digit_buf_next [DIGIT_LEN];
  logic [2:0]        kind_flags, kind_flags_next;
  logic [5:0]        servo_level, servo_level_next;
  logic [9:0]        dac_level, dac_level_next;
  logic              done;
  kind_t             kind_code;

  logic signed [15:0] d0, d1, d2, value;
  logic [6:0]         v_pos, v_tog, v_sel;
  logic [10:0]        servo_num;
  logic [21:0]        servo_prod;
  logic [9:0]         v_lit;
  logic [9:0]         dac_calc;
  logic [2:0]         found, matched;
  logic               mp, mt, ml;
  logic [7:0]         b;

  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  // message value, topic match and servo/DAC duty calculation
  always_comb begin
    d0 = $signed({8'b0, digit_buf[0]}) - $signed({8'b0, CH_ZERO});
    d1 = $signed({8'b0, digit_buf[1]}) - $signed({8'b0, CH_ZERO});
    d2 = $signed({8'b0, digit_buf[2]}) - $signed({8'b0, CH_ZERO});
    if (digit_buf[2] == 8'h00) begin
      if (digit_buf[1] == 8'h00) value = d0;
      else                       value = 16'sd10 * d0 + d1;
    end else begin
      value = 16'sd100 * d0 + 16'sd10 * d1 + d2;
    end

    if (value > 16'sd100)     v_pos = 7'd100;
    else if (value < 16'sd0)  v_pos = 7'd0;
    else                      v_pos = value[6:0];
    v_tog = (value > 16'sd0) ? 7'd100 : 7'd0;

    found = 3'b000;
    for (int i = TOPIC_LEN - 1; i >= 0; i--) begin
      mp = (i < KW_POS_LEN) && (topic_buf[i] == kw_char(KW_POS, KW_POS_LEN, i));
      mt = (i < KW_TOG_LEN) && (topic_buf[i] == kw_char(KW_TOG, KW_TOG_LEN, i));
      ml = (i < KW_LIT_LEN) && (topic_buf[i] == kw_char(KW_LIT, KW_LIT_LEN, i));
      if (mp)      found = 3'(1 << FLAG_POS);
      else if (mt) found = 3'(1 << FLAG_TOG);
      else if (ml) found = 3'(1 << FLAG_LIT);
    end
    matched = (kind_flags != 3'b000) ? kind_flags : found;

    v_sel      = matched[FLAG_POS] ? v_pos : v_tog;
    servo_num  = 11'd18 * {4'b0, v_sel} + 11'd99;
    servo_prod = {11'b0, servo_num} * RECIP_100;

    v_lit = {3'b0, value[6:0]};
    if (value <= 16'sd10)      dac_calc = 10'd600 - 10'd15 * v_lit;
    else if (value <= 16'sd20) dac_calc = 10'd500 - 10'd5 * v_lit;
    else if (value <= 16'sd35) dac_calc = 10'd460 - 10'd3 * v_lit;
    else                       dac_calc = 10'd400 - ((10'd3 * v_lit + 10'd1) >> 1);
  end

  // state update for the item in the input register
  always_comb begin
    b                  = s1_item.rx_byte;
    in_value_part_next = in_value_part;
    char_index_next    = char_index;
    topic_buf_next     = topic_buf;
    digit_buf_next     = digit_buf;
    kind_flags_next    = kind_flags;
    servo_level_next   = servo_level;
    dac_level_next     = dac_level;
    done               = 1'b0;

    if (s1_item.opcode == OP_CMP_EDGE) begin
      servo_level_next = SERVO_EDGE;
    end else if (b == CH_LF || b == CH_CR) begin
      done            = 1'b1;
      char_index_next = '0;
      kind_flags_next = matched;
      for (int j = 0; j < TOPIC_LEN; j++) topic_buf_next[j] = 8'h00;
      for (int j = 0; j < DIGIT_LEN; j++) digit_buf_next[j] = 8'h00;
      if (matched[FLAG_POS] || matched[FLAG_TOG]) begin
        servo_level_next = SERVO_RESET - {1'b0, servo_prod[21:17]};
      end else if (matched[FLAG_LIT] && value >= 16'sd1 && value <= 16'sd100) begin
        dac_level_next = dac_calc;
      end
    end else if (b == CH_COLON || b == CH_SPACE) begin
      in_value_part_next = 1'b1;
      char_index_next    = '0;
    end else if (b == CH_BANG) begin
      in_value_part_next = 1'b0;
      char_index_next    = '0;
      kind_flags_next    = 3'b000;
    end else if (in_value_part) begin
      if (char_index < IDX_W'(DIGIT_LEN)) begin
        for (int j = 0; j < DIGIT_LEN; j++) begin
          if (char_index == IDX_W'(j)) digit_buf_next[j] = b;
        end
        char_index_next = char_index + IDX_W'(1);
      end
    end else begin
      if (char_index < IDX_W'(TOPIC_LEN)) begin
        for (int j = 0; j < TOPIC_LEN; j++) begin
          if (char_index == IDX_W'(j)) topic_buf_next[j] = b;
        end
        char_index_next = char_index + IDX_W'(1);
      end
    end

    if (kind_flags_next[FLAG_POS])      kind_code = KIND_POSITION;
    else if (kind_flags_next[FLAG_TOG]) kind_code = KIND_TOGGLE;
    else if (kind_flags_next[FLAG_LIT]) kind_code = KIND_LIGHT;
    else                                kind_code = KIND_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value_part <= 1'b0;
      char_index    <= '0;
      kind_flags    <= 3'b000;
      servo_level   <= SERVO_RESET;
      dac_level     <= DAC_RESET;
      for (int j = 0; j < TOPIC_LEN; j++) topic_buf[j] <= 8'h00;
      for (int j = 0; j < DIGIT_LEN; j++) digit_buf[j] <= 8'h00;
    end else if (advance) begin
      in_value_part <= in_value_part_next;
      char_index    <= char_index_next;
      kind_flags    <= kind_flags_next;
      servo_level   <= servo_level_next;
      dac_level     <= dac_level_next;
      topic_buf     <= topic_buf_next;
      digit_buf     <= digit_buf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result.servo_duty   <= servo_level_next;
      result.dac_duty     <= dac_level_next;
      result.command_done <= done;
      result.topic_kind   <= kind_code;
    end
  end

`ifndef NO_ASSERTIONS
  a_kind_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(kind_flags))
    else $error("more than one topic kind latched");

  a_servo_range: assert property (@(posedge clk) disable iff (rst)
    servo_level >= SERVO_EDGE && servo_level <= SERVO_RESET)
    else $error("servo level out of range");

  a_dac_range: assert property (@(posedge clk) disable iff (rst)
    dac_level >= 10'd250 && dac_level <= DAC_RESET)
    else $error("dac level out of range");

  a_index_sat: assert property (@(posedge clk) disable iff (rst)
    char_index <= IDX_W'(TOPIC_LEN))
    else $error("char index past buffer length");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && done) |=> (char_index == '0 && result.command_done))
    else $error("message end did not reset the index");
`endif

endmodule
